// ===== src/abkf_pkg.sv =====
// Package for the angle / gyro-bias Kalman filter.
// Widths, formats, register codes and saturation helpers. No dependencies.
package abkf_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned NoiseW = 31;
	localparam int unsigned MsW = 12;
	localparam int unsigned FracQ28 = 28;

	localparam logic [31:0] RstAngleNoise = 32'd268435;
	localparam logic [31:0] RstBiasNoise = 32'd805306;
	localparam logic [31:0] RstMeasNoise = 32'd8053064;

	// register codes (word index on the APB port)
	localparam logic [1:0] RegAngleNoise = 2'd0;
	localparam logic [1:0] RegBiasNoise = 2'd1;
	localparam logic [1:0] RegMeasNoise = 2'd2;

	localparam logic signed [31:0] S32Max = 32'sh7fffffff;
	localparam logic signed [31:0] S32Min = 32'sh80000000;

	// saturate a 34-bit signed value to 32 bits
	function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v > 34'sh0_7fff_ffff) r = S32Max;
		else if (v < -34'sh0_8000_0000) r = S32Min;
		else r = v[31:0];
		return r;
	endfunction

	// round half up by 2^28 of a 64-bit product, then saturate
	function automatic logic signed [31:0] rnd_sat(input logic signed [63:0] p);
		logic signed [64:0] t;
		logic signed [36:0] q;
		t = {p[63], p} + 65'sd134217728;
		q = t[64:28];
		if (q > 37'sh0_7fff_ffff) return S32Max;
		else if (q < -37'sh0_8000_0000) return S32Min;
		else return q[31:0];
	endfunction

endpackage

// ===== src/abkf_if.sv =====
// Valid/ready channel interfaces carrying the filter's input and output fields.
// Uses abkf_pkg for field widths.
interface abkf_in_if;
	logic valid;
	logic ready;
	logic signed [31:0] measured_angle;
	logic signed [31:0] measured_rate;
	logic [abkf_pkg::MsW-1:0] elapsed_ms;
	modport source (output valid, measured_angle, measured_rate, elapsed_ms, input ready);
	modport sink (input valid, measured_angle, measured_rate, elapsed_ms, output ready);
endinterface

interface abkf_out_if;
	logic valid;
	logic ready;
	logic signed [31:0] angle_estimate;
	logic signed [31:0] rate_estimate;
	logic signed [31:0] bias_estimate;
	modport source (output valid, angle_estimate, rate_estimate, bias_estimate, input ready);
	modport sink (input valid, angle_estimate, rate_estimate, bias_estimate, output ready);
endinterface

// ===== src/angle_bias_kalman_filter_top.sv =====
// Channel      Dir  Fields
// in_ch        in   measured_angle, measured_rate, elapsed_ms
// out_ch       out  angle_estimate, rate_estimate, bias_estimate
// apb          in   noise registers 0..2 at byte offsets 0, 4, 8
// A word is taken only in idle. Its result is loaded into the output register when
// the update ends, and the next word can be taken in the cycle after the load.
// The update is one dt setup state, ten products through one shared 32x32 multiplier
// (one per step) and two divisions; with S not positive the divisions are skipped.
// A result still waiting in the output register stalls only the final load. Reset
// clears angle, bias, covariance and the output register and reloads the noise defaults.
// Depends on abkf_pkg, abkf_if, abkf_div.
module angle_bias_kalman_filter_top (
	input  logic clk,
	input  logic arst_n,
	abkf_in_if.sink in_ch,
	abkf_out_if.source out_ch,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [3:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_PREP = 7'b0000010,
		ST_CALC = 7'b0000100,
		ST_DIV0 = 7'b0001000,
		ST_DIV1 = 7'b0010000,
		ST_POST = 7'b0100000,
		ST_OUT  = 7'b1000000
	} state_t;

	state_t state_q;
	logic [4:0] step_q;
	logic [30:0] qa_q, qb_q, rm_q;
	logic signed [31:0] ang_q, bias_q, p00_q, p01_q, p10_q, p11_q;
	logic signed [31:0] z_q, dt_q, rate_q, inner_q, k0_q, k1_q, y_q, m_q;
	logic signed [31:0] ma, mb;
	logic signed [63:0] prod;
	logic signed [31:0] pr;
	logic [24:0] ms_mul;
	logic [5:0] ms_a, ms_a_q;
	logic [6:0] ms_b, ms_b_q;
	logic [12:0] dt_fx;
	logic [25:0] dt_fm;
	logic [31:0] dt_val;
	logic div_start, div_done;
	logic signed [31:0] div_p, div_q, s_val;
	logic wr;
	logic load_out;
	logic [1:0] widx;

	assign pready = 1'b1;
	assign widx = paddr[3:2];
	assign wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qa_q <= abkf_pkg::RstAngleNoise[30:0];
			qb_q <= abkf_pkg::RstBiasNoise[30:0];
			rm_q <= abkf_pkg::RstMeasNoise[30:0];
		end else if (wr) begin
			case (widx)
				abkf_pkg::RegAngleNoise: qa_q <= pwdata[30:0];
				abkf_pkg::RegBiasNoise: qb_q <= pwdata[30:0];
				abkf_pkg::RegMeasNoise: rm_q <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (widx)
			abkf_pkg::RegAngleNoise: prdata = {1'b0, qa_q};
			abkf_pkg::RegBiasNoise: prdata = {1'b0, qb_q};
			abkf_pkg::RegMeasNoise: prdata = {1'b0, rm_q};
			default: prdata = '0;
		endcase
	end

	// shared multiplier operand select, one product per step
	always_comb begin
		ma = dt_q;
		mb = rate_q;
		case (step_q)
			5'd0: begin ma = dt_q; mb = rate_q; end
			5'd1: begin ma = dt_q; mb = p11_q; end
			5'd2: begin ma = dt_q; mb = inner_q; end
			5'd3: begin ma = dt_q; mb = $signed({1'b0, qb_q}); end
			5'd4: begin ma = k0_q; mb = y_q; end
			5'd5: begin ma = k1_q; mb = y_q; end
			5'd6: begin ma = k0_q; mb = p00_q; end
			5'd7: begin ma = k0_q; mb = p01_q; end
			5'd8: begin ma = k1_q; mb = p00_q; end
			5'd9: begin ma = k1_q; mb = p01_q; end
			default: ;
		endcase
	end
	assign prod = ma * mb;
	assign pr = abkf_pkg::rnd_sat(prod);

	// dt = (ms*2^28 + 500)/1000 = (ms*2^25 + 62)/125. Split ms = 125*a + b
	// (a = ms*4195 >> 19, exact for ms < 6026); since 2^25 = 125*268435 + 57,
	// dt = a*2^25 + b*268435 + (57*b + 62)/125, the last by *8389 >> 20.
	assign ms_mul = 25'(in_ch.elapsed_ms) * 25'd4195;
	assign ms_a = ms_mul[24:19];
	assign ms_b = 7'(in_ch.elapsed_ms - 12'(ms_a) * 12'd125);
	assign dt_fx = 13'(ms_b_q) * 13'd57 + 13'd62;
	assign dt_fm = 26'(dt_fx) * 26'd8389;
	assign dt_val = {1'b0, ms_a_q, 25'd0} + 32'(ms_b_q) * 32'd268435 + 32'(dt_fm[25:20]);

	assign s_val = abkf_pkg::sat34(34'(p00_q) + 34'(rm_q));
	assign div_p = (state_q == ST_IDLE || state_q == ST_CALC) ? p00_q : p10_q;
	assign div_start = (state_q == ST_CALC && step_q == 5'd3) ||
		(state_q == ST_DIV0 && div_done);

	abkf_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start && s_val > 0),
		.p(div_p), .s(s_val), .done(div_done), .q(div_q)
	);

	assign load_out = (state_q == ST_OUT) && (!out_ch.valid || out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			ang_q <= '0; bias_q <= '0;
			p00_q <= '0; p01_q <= '0; p10_q <= '0; p11_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						z_q <= in_ch.measured_angle;
						ms_a_q <= ms_a;
						ms_b_q <= ms_b;
						rate_q <= abkf_pkg::sat34(34'(in_ch.measured_rate) - 34'(bias_q));
						step_q <= '0;
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					dt_q <= $signed(dt_val);
					step_q <= '0;
					state_q <= ST_CALC;
				end
				ST_CALC: begin
					step_q <= step_q + 5'd1;
					case (step_q)
						5'd0: ang_q <= abkf_pkg::sat34(34'(ang_q) + 34'(pr));
						5'd1: begin
							m_q <= pr;
							inner_q <= abkf_pkg::sat34(34'(pr) - 34'(p01_q) - 34'(p10_q)
								+ 34'(qa_q));
						end
						5'd2: begin
							p00_q <= abkf_pkg::sat34(34'(p00_q) + 34'(pr));
							p01_q <= abkf_pkg::sat34(34'(p01_q) - 34'(m_q));
							p10_q <= abkf_pkg::sat34(34'(p10_q) - 34'(m_q));
						end
						default: begin
							p11_q <= abkf_pkg::sat34(34'(p11_q) + 34'(pr));
							y_q <= abkf_pkg::sat34(34'(z_q) - 34'(ang_q));
							if (s_val > 0) begin
								state_q <= ST_DIV0;
							end else begin
								k0_q <= '0; k1_q <= '0;
								step_q <= 5'd4;
								state_q <= ST_POST;
							end
						end
					endcase
				end
				ST_DIV0: if (div_done) begin
					k0_q <= div_q;
					state_q <= ST_DIV1;
				end
				ST_DIV1: if (div_done) begin
					k1_q <= div_q;
					step_q <= 5'd4;
					state_q <= ST_POST;
				end
				ST_POST: begin
					step_q <= step_q + 5'd1;
					case (step_q)
						5'd4: ang_q <= abkf_pkg::sat34(34'(ang_q) + 34'(pr));
						5'd5: bias_q <= abkf_pkg::sat34(34'(bias_q) + 34'(pr));
						5'd6: m_q <= pr;
						5'd7: inner_q <= pr;
						5'd8: begin
							y_q <= pr;
							p00_q <= abkf_pkg::sat34(34'(p00_q) - 34'(m_q));
						end
						default: begin
							p01_q <= abkf_pkg::sat34(34'(p01_q) - 34'(inner_q));
							p10_q <= abkf_pkg::sat34(34'(p10_q) - 34'(y_q));
							p11_q <= abkf_pkg::sat34(34'(p11_q) - 34'(pr));
							state_q <= ST_OUT;
						end
					endcase
				end
				ST_OUT: if (load_out) begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register: frees the core while a word waits for the sink
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.valid <= 1'b0;
			out_ch.angle_estimate <= '0;
			out_ch.rate_estimate <= '0;
			out_ch.bias_estimate <= '0;
		end else if (load_out) begin
			out_ch.angle_estimate <= ang_q;
			out_ch.rate_estimate <= rate_q;
			out_ch.bias_estimate <= bias_q;
			out_ch.valid <= 1'b1;
		end else if (out_ch.ready) begin
			out_ch.valid <= 1'b0;
		end
	end

	assign in_ch.ready = (state_q == ST_IDLE);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.ready) |=> (out_ch.valid
		&& $stable(out_ch.angle_estimate) && $stable(out_ch.bias_estimate)))
		else $error("output word dropped");
	a_out_after_post: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_ch.valid) |-> $past(state_q == ST_OUT)) else $error("bad out");
	a_div_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV1) |-> $past(state_q == ST_DIV0 || state_q == ST_DIV1))
		else $error("div order");
endmodule

// ===== src/abkf_div.sv =====
// Radix-2 restoring divider: quotient of (p * 2^28) / s, truncated, saturated.
// Uses abkf_pkg. s must be positive when started.
module abkf_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [31:0] p,
	input  logic signed [31:0] s,
	output logic done,
	output logic signed [31:0] q
);
	// |p|*2^28 fits in 60 bits
	logic [59:0] num_q;
	logic [59:0] quo_q;
	logic [31:0] rem_q;
	logic [30:0] den_q;
	logic neg_q;
	logic busy_q;
	logic [5:0] cnt_q;
	logic [32:0] trial;
	logic [31:0] pabs;
	logic [60:0] mag;

	assign pabs = p[31] ? 32'(-p) : 32'(p);
	assign trial = {rem_q, num_q[59]} - {2'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd60;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {pabs[31:0], 28'd0};
			quo_q <= '0;
			rem_q <= '0;
			den_q <= s[30:0];
			neg_q <= p[31];
		end else if (busy_q) begin
			num_q <= {num_q[58:0], 1'b0};
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[58:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], num_q[59]};
				quo_q <= {quo_q[58:0], 1'b0};
			end
		end
	end

	always_comb begin
		mag = neg_q ? -{1'b0, quo_q} : {1'b0, quo_q};
		if (!neg_q && quo_q > 60'h7fffffff) q = abkf_pkg::S32Max;
		else if (neg_q && quo_q > 60'h80000000) q = abkf_pkg::S32Min;
		else q = mag[31:0];
	end
endmodule

// ===== bench/testbench.sv =====
// Testbench for the angle / gyro-bias Kalman filter: directed and random words
// checked against a fixed-point predictor of the filter. Depends on abkf_pkg,
// abkf_if and angle_bias_kalman_filter_top.
`timescale 1ns / 100ps

module testbench;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	abkf_in_if in_ch ();
	abkf_out_if out_ch ();

	angle_bias_kalman_filter_top u_top (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #2 clk = ~clk;

	typedef struct packed {
		logic signed [31:0] angle;
		logic signed [31:0] rate;
		logic signed [31:0] bias;
	} estimate_t;

	estimate_t est_q[$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	// filter state and noise registers of the predictor
	longint f_angle, f_bias;
	longint f_cov[4];
	longint q_angle, q_bias, r_meas;

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// Q4.28 times anything, rounded half up, saturated
	function automatic longint qmul(longint a, longint b);
		longint t;
		t = a * b + (64'sd1 <<< 27);
		return clamp32(t >>> 28);
	endfunction

	function automatic longint kgain(longint p, longint s);
		if (s <= 0) return 0;
		return clamp32((p * (64'sd1 <<< 28)) / s);
	endfunction

	function automatic estimate_t filter_update(logic signed [31:0] z_in,
			logic signed [31:0] w_in, logic [abkf_pkg::MsW-1:0] ms);
		longint z, w, dt, p00, p01, p10, p11, rate, inner, s, k0, k1, y;
		estimate_t e;
		z = z_in;
		w = w_in;
		dt = (longint'(ms) * (64'sd1 <<< 28) + 500) / 1000;
		p00 = f_cov[0]; p01 = f_cov[1]; p10 = f_cov[2]; p11 = f_cov[3];
		rate = clamp32(w - f_bias);
		f_angle = clamp32(f_angle + qmul(dt, rate));
		inner = clamp32(qmul(dt, p11) - p01 - p10 + q_angle);
		p00 = clamp32(p00 + qmul(dt, inner));
		p01 = clamp32(p01 - qmul(dt, p11));
		p10 = clamp32(p10 - qmul(dt, p11));
		p11 = clamp32(p11 + qmul(dt, q_bias));
		s = clamp32(p00 + r_meas);
		k0 = kgain(p00, s);
		k1 = kgain(p10, s);
		y = clamp32(z - f_angle);
		f_angle = clamp32(f_angle + qmul(k0, y));
		f_bias = clamp32(f_bias + qmul(k1, y));
		f_cov[0] = clamp32(p00 - qmul(k0, p00));
		f_cov[1] = clamp32(p01 - qmul(k0, p01));
		f_cov[2] = clamp32(p10 - qmul(k1, p00));
		f_cov[3] = clamp32(p11 - qmul(k1, p01));
		e.angle = f_angle[31:0];
		e.rate = rate[31:0];
		e.bias = f_bias[31:0];
		return e;
	endfunction

	initial begin
		in_ch.valid = 1'b0;
		in_ch.measured_angle = '0;
		in_ch.measured_rate = '0;
		in_ch.elapsed_ms = '0;
		out_ch.ready = 1'b0;
	end

	// receiver: random stalls, checks each word against the oldest estimate
	always @(posedge clk) begin
		if (out_ch.valid && out_ch.ready) begin
			if (est_q.size() == 0) begin
				$error("unexpected word angle=%h", out_ch.angle_estimate);
				errors++;
			end else begin
				estimate_t e;
				e = est_q.pop_front();
				if (out_ch.angle_estimate !== e.angle) begin
					$error("angle_estimate exp %h got %h", e.angle, out_ch.angle_estimate);
					errors++;
				end
				if (out_ch.rate_estimate !== e.rate) begin
					$error("rate_estimate exp %h got %h", e.rate, out_ch.rate_estimate);
					errors++;
				end
				if (out_ch.bias_estimate !== e.bias) begin
					$error("bias_estimate exp %h got %h", e.bias, out_ch.bias_estimate);
					errors++;
				end
			end
		end
		out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// valid stays up after the accepting edge; drain() drops it, the next call drops it or sends a new word
	task automatic send_word(logic signed [31:0] z, logic signed [31:0] w,
			logic [abkf_pkg::MsW-1:0] ms);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.measured_angle <= z;
		in_ch.measured_rate <= w;
		in_ch.elapsed_ms <= ms;
		est_q.push_back(filter_update(z, w, ms));
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (est_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	// block is idle whenever this is called
	task automatic write_reg(logic [1:0] idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == abkf_pkg::RegAngleNoise) q_angle = value[30:0];
		else if (idx == abkf_pkg::RegBiasNoise) q_bias = value[30:0];
		else if (idx == abkf_pkg::RegMeasNoise) r_meas = value[30:0];
		@(posedge clk);
	endtask

	task automatic test_directed();
		send_word(32'sh0001_0000, 32'sh0000_8000, 12'd10);
		send_word(abkf_pkg::S32Max, abkf_pkg::S32Max, 12'd4095);
		send_word(abkf_pkg::S32Min, abkf_pkg::S32Min, 12'd4095);
		send_word(abkf_pkg::S32Max, abkf_pkg::S32Min, 12'd0);
		send_word(abkf_pkg::S32Min, abkf_pkg::S32Max, 12'd1);
		send_word('0, '0, 12'd0);
		send_word(32'shffff_ffff, 32'sh0000_0001, 12'hfff);
		send_word(32'sh5555_5555, 32'shaaaa_aaaa, 12'h555);
		send_word(32'shaaaa_aaaa, 32'sh5555_5555, 12'haaa);
		drain();
	endtask

	// zero measurement and angle noise, then full-scale noise registers
	task automatic test_zero_noise();
		write_reg(abkf_pkg::RegMeasNoise, 32'd0);
		write_reg(abkf_pkg::RegAngleNoise, 32'd0);
		send_word(32'sh0010_0000, 32'sh0001_0000, 12'd0);
		send_word(32'sh0010_0000, 32'sh0001_0000, 12'd20);
		drain();
		write_reg(abkf_pkg::RegAngleNoise, 32'h7fff_ffff);
		write_reg(abkf_pkg::RegBiasNoise, 32'hffff_ffff);
		write_reg(abkf_pkg::RegMeasNoise, 32'hffff_ffff);
		send_word(abkf_pkg::S32Max, abkf_pkg::S32Min, 12'd4095);
		send_word(abkf_pkg::S32Min, abkf_pkg::S32Max, 12'd4095);
		drain();
	endtask

	task automatic test_random(int count);
		int k;
		logic signed [31:0] z, w;
		logic [abkf_pkg::MsW-1:0] ms;
		for (k = 0; k < count; k++) begin
			if ($urandom_range(9) < 8) begin
				// plausible IMU traffic, small angles and a short elapsed_ms step
				z = $signed($urandom_range(0, 32'h00b4_0000 * 2)) - 32'sh00b4_0000;
				w = $signed($urandom_range(0, 32'h01f4_0000 * 2)) - 32'sh01f4_0000;
				ms = $urandom_range(0, 20);
			end else begin
				z = $urandom;
				w = $urandom;
				ms = $urandom_range(0, 4095);
			end
			send_word(z, w, ms);
		end
		drain();
	endtask

	task automatic restore_defaults();
		write_reg(abkf_pkg::RegAngleNoise, abkf_pkg::RstAngleNoise);
		write_reg(abkf_pkg::RegBiasNoise, abkf_pkg::RstBiasNoise);
		write_reg(abkf_pkg::RegMeasNoise, abkf_pkg::RstMeasNoise);
	endtask

	initial begin
		f_angle = 0; f_bias = 0;
		foreach (f_cov[i]) f_cov[i] = 0;
		q_angle = abkf_pkg::RstAngleNoise;
		q_bias = abkf_pkg::RstBiasNoise;
		r_meas = abkf_pkg::RstMeasNoise;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_zero_noise();
		restore_defaults();
		send_idle_pct = 23; recv_idle_pct = 87;
		test_random(400);
		write_reg(abkf_pkg::RegAngleNoise, $urandom);
		write_reg(abkf_pkg::RegBiasNoise, $urandom);
		write_reg(abkf_pkg::RegMeasNoise, $urandom_range(1, 32'h7fff_ffff));
		send_idle_pct = 87; recv_idle_pct = 23;
		test_random(400);
		write_reg(abkf_pkg::RegMeasNoise, 32'd1);
		send_idle_pct = 0; recv_idle_pct = 0;
		test_random(200);
		restore_defaults();
		test_random(300);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// slowest run: ~1300 words plus heavy stalls
	initial begin
		#20ms;
		$display("FAIL");
		$finish;
	end

endmodule
